### design/sorted_key_value_table_defines.svh
// Assertion macros for the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SKV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SKV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/skvt_pkg.sv
// Shared types and codes for the sorted key/value table.
package skvt_pkg;
    typedef enum logic [3:0] {
        ACT_INSERT = 4'd0, ACT_LOOKUP = 4'd1, ACT_UPDATE = 4'd2, ACT_UPD_RANGE = 4'd3,
        ACT_DELETE = 4'd4, ACT_DEL_RANGE = 4'd5, ACT_READ_RANGE = 4'd6, ACT_MIN = 4'd7,
        ACT_MAX = 4'd8, ACT_ALL = 4'd9
    } t_action;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Shared comparator request and answer
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_rsp;
endpackage

### design/skvt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module skvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/skvt_cmp.sv
// Shared 64-bit magnitude comparator used by every binary search step.
module skvt_cmp
    import skvt_pkg::*;
(
    input  t_cmp_req i_req,
    output t_cmp_rsp o_rsp
);
    always_comb begin
        o_rsp.lt = i_req.a < i_req.b;
        o_rsp.eq = i_req.a == i_req.b;
    end
endmodule

### design/sorted_key_value_table.sv
// Sorted key/value table: records live in two RAMs kept in ascending key
// order. One request is worked on at a time and s_axis_tready is low until
// its last result has been taken. A binary search uses one comparator and one
// RAM read per step, a read then a decision, over up to log2(CAPACITY)+1
// steps; range actions search twice, once per bound, unless key_high < key.
// Insert and delete then move the tail one entry at a time, a read then a
// write; update range walks its span with a read and a write per entry, and
// reads emit one result per entry read, waiting while the output is stalled.
// No clearing pass is needed after reset.
`include "sorted_key_value_table_defines.svh"
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] action, [67:4] key, [131:68] key_high, [195:132] value
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [65:2] rec_key, [129:66] rec_value, [136:130] entry_count
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SRCH   = 11'b00000000010,
        S_SWAIT  = 11'b00000000100,
        S_DECIDE = 11'b00000001000,
        S_INS    = 11'b00000010000,
        S_INSW   = 11'b00000100000,
        S_DEL    = 11'b00001000000,
        S_DELW   = 11'b00010000000,
        S_WALK   = 11'b00100000000,
        S_WALKW  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_action r_act;
    logic [KEY_BITS-1:0] r_key, r_khi;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0] r_cnt, r_lo, r_hi, r_a, r_i, r_end;
    logic r_phase;  // 0: lower bound search, 1: upper bound search
    // output register
    logic r_ov, r_olast;
    logic [1:0] r_ost;
    logic [63:0] r_okey, r_oval;
    logic [CW-1:0] r_ocnt;

    // RAM ports
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [KEY_BITS-1:0] kwd, krd;
    logic [VALUE_BITS-1:0] vwd, vrd;

    skvt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(kwd),
        .i_raddr(ram_raddr), .o_rdata(krd));
    skvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(vwd),
        .i_raddr(ram_raddr), .o_rdata(vrd));

    // Comparator: stored key against the search target
    t_cmp_req cmp_req;
    t_cmp_rsp cmp_rsp;
    skvt_cmp u_cmp (.i_req(cmp_req), .o_rsp(cmp_rsp));

    logic [CW-1:0] mid;
    logic [KEY_BITS-1:0] target;
    logic go_right;
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign target = r_phase ? r_khi : r_key;
    always_comb begin
        cmp_req.a = 64'(krd);
        cmp_req.b = 64'(target);
    end
    assign go_right = cmp_rsp.lt || (r_phase && cmp_rsp.eq);

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;

    // Register updates driven by the sequencer
    logic set_out, set_last;
    logic [1:0] set_st;
    logic [63:0] set_k, set_v;
    logic [CW-1:0] n_cnt, n_lo, n_hi, n_a, n_i, n_end;
    logic n_phase;
    logic kk_le;
    assign kk_le = !(r_khi < r_key);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_lo = r_lo; n_hi = r_hi; n_a = r_a; n_i = r_i; n_end = r_end;
        n_phase = r_phase;
        set_out = 1'b0; set_last = 1'b1; set_st = ST_NOTFOUND; set_k = '0; set_v = '0;
        ram_we = 1'b0; ram_waddr = '0; ram_raddr = mid[AW-1:0];
        kwd = r_key; vwd = r_val;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_lo = '0; n_hi = r_cnt; n_phase = 1'b0;
                    n_state = S_SRCH;
                    priority if (s_axis_tdata[3:0] == ACT_INSERT && r_cnt == CW'(CAPACITY)) begin
                        set_out = 1'b1; set_st = ST_FULL; n_state = S_IDLE;
                    end else if (s_axis_tdata[3:0] == ACT_MIN || s_axis_tdata[3:0] == ACT_MAX ||
                                 s_axis_tdata[3:0] == ACT_ALL) begin
                        if (r_cnt == '0) begin
                            set_out = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_i = (s_axis_tdata[3:0] == ACT_MAX) ? r_cnt - 1'b1 : '0;
                            n_end = (s_axis_tdata[3:0] == ACT_ALL) ? r_cnt : n_i + 1'b1;
                            n_state = S_WALK;
                        end
                    end else if (s_axis_tdata[3:0] > ACT_ALL) begin
                        set_out = 1'b1; n_state = S_IDLE;
                    end
                end
            end
            // Issue a read of the middle entry
            S_SRCH: begin
                if (r_lo < r_hi) n_state = S_SWAIT;
                else n_state = S_DECIDE;
            end
            S_SWAIT: begin
                if (go_right) n_lo = mid + 1'b1;
                else n_hi = mid;
                n_state = S_SRCH;
            end
            S_DECIDE: begin
                ram_raddr = r_lo[AW-1:0];
                if (!r_phase) n_a = r_lo;
                unique case (r_act)
                    ACT_INSERT: begin
                        n_i = r_cnt; n_state = S_INS;
                    end
                    ACT_LOOKUP, ACT_UPDATE, ACT_DELETE: begin
                        n_i = r_lo; n_end = r_lo + 1'b1;
                        if (r_lo < r_cnt) n_state = S_WALK;
                        else begin set_out = 1'b1; n_state = S_IDLE; end
                    end
                    default: begin
                        if (!r_phase && kk_le) begin
                            n_phase = 1'b1; n_lo = '0; n_hi = r_cnt; n_state = S_SRCH;
                        end else begin
                            n_i = r_a; n_end = r_phase ? r_lo : r_lo;
                            if (!r_phase) n_i = r_lo;
                            if (r_phase && r_lo <= r_a) n_end = r_a;
                            if (n_end == n_i) begin
                                set_out = 1'b1; n_state = S_IDLE;
                            end else if (r_act == ACT_DEL_RANGE) begin
                                n_lo = n_i; n_hi = n_end; n_i = n_end; n_state = S_DEL;
                            end else n_state = S_WALK;
                        end
                    end
                endcase
            end
            // Insert: shift tail up one entry at a time, from the top
            S_INS: begin
                ram_raddr = AW'(r_i - 1'b1);
                if (r_i == r_a) begin
                    ram_we = 1'b1; ram_waddr = r_a[AW-1:0];
                    n_cnt = r_cnt + 1'b1;
                    set_out = 1'b1; set_st = ST_OK; set_k = 64'(r_key); set_v = 64'(r_val);
                    n_state = S_IDLE;
                end else n_state = S_INSW;
            end
            S_INSW: begin
                ram_we = 1'b1; ram_waddr = r_i[AW-1:0]; kwd = krd; vwd = vrd;
                n_i = r_i - 1'b1; n_state = S_INS;
            end
            // Delete span [r_lo, r_hi): copy entry r_i down to r_lo
            S_DEL: begin
                ram_raddr = r_i[AW-1:0];
                if (r_i == r_cnt) begin
                    n_cnt = r_cnt - (r_hi - r_a);
                    set_out = 1'b1; set_st = ST_OK; set_k = r_okey; set_v = r_oval;
                    if (r_act != ACT_DELETE) begin set_k = '0; set_v = '0; end
                    n_state = S_IDLE;
                end else n_state = S_DELW;
            end
            S_DELW: begin
                ram_we = 1'b1; ram_waddr = r_lo[AW-1:0]; kwd = krd; vwd = vrd;
                n_lo = r_lo + 1'b1; n_i = r_i + 1'b1; n_state = S_DEL;
            end
            // Walk over [r_i, r_end): read, update or emit each entry
            S_WALK: begin
                ram_raddr = r_i[AW-1:0];
                n_state = S_WALKW;
            end
            S_WALKW: begin
                unique case (r_act)
                    ACT_LOOKUP, ACT_UPDATE, ACT_DELETE: begin
                        if (krd != r_key) begin
                            set_out = 1'b1; n_state = S_IDLE;
                        end else if (r_act == ACT_DELETE) begin
                            n_a = r_i; n_lo = r_i; n_hi = r_i + 1'b1; n_i = r_i + 1'b1;
                            n_state = S_DEL;
                        end else begin
                            set_out = 1'b1; set_st = ST_OK; set_k = 64'(krd);
                            set_v = 64'((r_act == ACT_UPDATE) ? r_val : vrd);
                            if (r_act == ACT_UPDATE) begin
                                ram_we = 1'b1; ram_waddr = r_i[AW-1:0];
                            end
                            n_state = S_IDLE;
                        end
                    end
                    ACT_UPD_RANGE: begin
                        ram_we = 1'b1; ram_waddr = r_i[AW-1:0]; kwd = krd;
                        n_i = r_i + 1'b1;
                        if (n_i == r_end) begin
                            set_out = 1'b1; set_st = ST_OK; n_state = S_IDLE;
                        end else n_state = S_WALK;
                    end
                    default: begin
                        set_out = 1'b1; set_st = ST_OK; set_k = 64'(krd); set_v = 64'(vrd);
                        n_i = r_i + 1'b1;
                        set_last = (n_i == r_end);
                        n_state = set_last ? S_IDLE : S_OUT;
                    end
                endcase
            end
            // Wait for the emitted result to drain before the next read
            S_OUT: begin
                if (!r_ov || out_acc) n_state = S_WALK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Capture the removed record for a single delete
    logic del_cap;
    assign del_cap = (r_state == S_WALKW) && (r_act == ACT_DELETE) && (krd == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (set_out) r_ov <= 1'b1;
            else if (out_acc) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo; r_hi <= n_hi; r_a <= n_a; r_i <= n_i; r_end <= n_end;
        r_phase <= n_phase;
        if (in_acc) begin
            r_act <= t_action'(s_axis_tdata[3:0]);
            r_key <= s_axis_tdata[4 +: KEY_BITS];
            r_khi <= s_axis_tdata[68 +: KEY_BITS];
            r_val <= s_axis_tdata[132 +: VALUE_BITS];
        end
        if (del_cap) begin
            r_okey <= 64'(krd); r_oval <= 64'(vrd);
        end else if (set_out) begin
            r_ost <= set_st; r_okey <= set_k; r_oval <= set_v;
            r_ocnt <= n_cnt; r_olast <= set_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'd0, 7'(r_ocnt), r_oval, r_okey, r_ost};

    `SKV_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(CAPACITY))
    `SKV_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `SKV_ASSERT_NXT(a_full_nochange, i_clk, i_rst_n,
        in_acc && s_axis_tdata[3:0] == ACT_INSERT && r_cnt == CW'(CAPACITY),
        r_ov && r_ost == ST_FULL)
endmodule
